// ===== rtl/sha_pkg.sv =====
`timescale 1ns / 1ps
package sha_pkg;

    localparam int unsigned BlockBytes = 64;
    localparam int unsigned Rounds     = 64;
    localparam int unsigned DigestWords = 8;
    localparam int unsigned FifoDepthDefault = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_beat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } t_core_state;

    typedef logic [31:0] t_word8 [8];

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] h;
        case (idx)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

endpackage

// ===== rtl/sha_if.sv =====
`timescale 1ns / 1ps
interface sha_in_if;
    logic             valid;
    logic             ready;
    sha_pkg::t_in_beat payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface sha_out_if;
    logic              valid;
    logic              ready;
    sha_pkg::t_out_beat payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/sha_fifo.sv =====
`timescale 1ns / 1ps
module sha_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sha_pkg::t_in_beat i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output sha_pkg::t_in_beat o_data
);
    import sha_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_in_beat        r_mem [DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [AW:0]     r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_push && !o_full) - (AW+1)'(i_pop && !o_empty);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH))
        else $error("fifo count overflow");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !i_pop) |=> o_full)
        else $error("fifo lost full");
    a_pop_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !o_empty && !i_push) |=> r_cnt == $past(r_cnt) - 1'b1)
        else $error("fifo pop miscount");

endmodule

// ===== rtl/sha_core.sv =====
`timescale 1ns / 1ps
module sha_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  sha_pkg::t_in_beat i_data,
    output logic              o_pop,
    sha_out_if.source         o_res
);
    import sha_pkg::*;

    t_core_state r_state, n_state;

    logic [31:0] r_blk [16];    // block bytes, big-endian within each word
    logic [5:0]  r_fill;
    logic [63:0] r_total;
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];
    logic [5:0]  r_rnd;
    logic        r_final;   // block being compressed closes the message
    logic        r_second;  // a length-only block still follows
    logic [63:0] r_len;
    logic [2:0]  r_widx;
    // pending end after a full block that also ended the message
    logic        r_pend_end;

    // control outputs
    logic take, start_blk;
    t_in_beat beat;
    assign beat = i_data;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    if (beat.byte_valid && r_fill == 6'd63) n_state = ST_ROUND;
                    else if (beat.end_of_message) n_state = ST_PAD;
                end
            end
            ST_PAD:   n_state = ST_ROUND;
            ST_ROUND: if (r_rnd == 6'd63) n_state = ST_FOLD;
            ST_FOLD: begin
                if (r_second) n_state = ST_PAD;
                else if (r_final) n_state = ST_EMIT;
                else if (r_pend_end) n_state = ST_PAD;
                else n_state = ST_IDLE;
            end
            ST_EMIT: if (o_res.ready && r_widx == 3'd7) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        take      = (r_state == ST_IDLE) && !i_empty;
        start_blk = take && beat.byte_valid && r_fill == 6'd63;
        o_pop     = take;
        o_res.valid = (r_state == ST_EMIT);
        o_res.payload.digest_word = r_h[r_widx];
        o_res.payload.word_index  = r_widx;
        o_res.payload.last_word   = (r_widx == 3'd7);
    end

    // round datapath
    logic [31:0] s0, s1, ch, mj, t1, t2, wn, ws0, ws1, wcur;
    assign wcur = r_w[0];
    assign s1 = {r_v[4][5:0], r_v[4][31:6]} ^ {r_v[4][10:0], r_v[4][31:11]}
              ^ {r_v[4][24:0], r_v[4][31:25]};
    assign ch = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign t1 = r_v[7] + s1 + ch + round_k(r_rnd) + wcur;
    assign s0 = {r_v[0][1:0], r_v[0][31:2]} ^ {r_v[0][12:0], r_v[0][31:13]}
              ^ {r_v[0][21:0], r_v[0][31:22]};
    assign mj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t2 = s0 + mj;
    assign ws0 = {r_w[1][6:0], r_w[1][31:7]} ^ {r_w[1][17:0], r_w[1][31:18]}
               ^ {3'b0, r_w[1][31:3]};
    assign ws1 = {r_w[14][16:0], r_w[14][31:17]} ^ {r_w[14][18:0], r_w[14][31:19]}
               ^ {10'b0, r_w[14][31:10]};
    assign wn = ws1 + r_w[9] + ws0 + r_w[0];

    // padded view of the block: bytes kept below fill, 0x80 at fill, zeros above
    logic [31:0] pad_keep, pad_mark;
    logic [31:0] padw [16];
    logic [63:0] len_now;
    assign pad_keep = ~(32'hffffffff >> {r_fill[1:0], 3'b000});
    assign pad_mark = 32'h80000000 >> {r_fill[1:0], 3'b000};
    assign len_now  = r_total + {55'd0, r_fill, 3'd0};

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            if (4'(i) < r_fill[5:2]) padw[i] = r_blk[i];
            else if (4'(i) > r_fill[5:2]) padw[i] = '0;
            else padw[i] = (r_blk[i] & pad_keep) | pad_mark;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_fill     <= '0;
            r_total    <= '0;
            r_final    <= 1'b0;
            r_second   <= 1'b0;
            r_pend_end <= 1'b0;
            r_rnd      <= '0;
            r_widx     <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= init_hash(3'(i));
        end else begin
            r_state <= n_state;
            if (take && beat.byte_valid) begin
                r_blk[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <= beat.data_byte;
                r_fill <= r_fill + 1'b1;
            end
            if (start_blk) begin
                r_pend_end <= beat.end_of_message;
                r_final    <= 1'b0;
                r_rnd      <= '0;
                for (int i = 0; i < 15; i++) r_w[i] <= r_blk[i];
                r_w[15] <= {r_blk[15][31:8], beat.data_byte};
                for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
            end
            if (r_state == ST_PAD) begin
                r_rnd <= '0;
                for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                if (!r_second && r_fill > 6'd55) begin
                    // length does not fit: marker block now, length block next
                    r_second <= 1'b1;
                    r_final  <= 1'b0;
                    r_len    <= len_now;
                    for (int i = 0; i < 16; i++) r_w[i] <= padw[i];
                end else begin
                    r_second <= 1'b0;
                    r_final  <= 1'b1;
                    r_pend_end <= 1'b0;
                    for (int i = 0; i < 14; i++) begin
                        if (r_second) r_w[i] <= '0;
                        else r_w[i] <= padw[i];
                    end
                    r_w[14] <= r_second ? r_len[63:32] : len_now[63:32];
                    r_w[15] <= r_second ? r_len[31:0] : len_now[31:0];
                end
            end
            if (r_state == ST_ROUND) begin
                r_rnd <= r_rnd + 1'b1;
                r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + t1;
                r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                r_v[0] <= t1 + t2;
                for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                r_w[15] <= wn;
            end
            if (r_state == ST_FOLD) begin
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                if (!r_final && !r_second) r_total <= r_total + 64'd512;
                if (r_final) r_widx <= '0;
            end
            if (r_state == ST_EMIT && o_res.ready) begin
                r_widx <= r_widx + 1'b1;
                if (r_widx == 3'd7) begin
                    for (int i = 0; i < 8; i++) r_h[i] <= init_hash(3'(i));
                    r_fill  <= '0;
                    r_total <= '0;
                    r_final <= 1'b0;
                end
            end
        end
    end

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> r_state == ST_IDLE)
        else $error("pop outside idle");
    a_emit_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.ready && r_widx != 3'd7) |=> o_res.valid)
        else $error("digest beats broken");
    a_round_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && r_rnd == 6'd63) |=> r_state == ST_FOLD)
        else $error("round count slip");

endmodule

// ===== rtl/sha256_byte_stream_hasher.sv =====
`timescale 1ns / 1ps
// channel   | dir | beat contents
// i_in      | in  | data_byte, byte_valid, end_of_message
// o_res     | out | digest_word, word_index, last_word
//
// beats leave the fifo only while the core is idle; the 64th byte of a block
// starts the rounds and then a fold in the shared round unit
// message end: one or two padded blocks (pad, rounds, fold), then 8 digest beats
// input beats queue in a small fifo while the round unit is busy
// synchronous active-low reset returns the chain value to the initial hash
// output stalls hold the digest word; the fifo fills and then drops ready
module sha256_byte_stream_hasher #(
    parameter int unsigned FIFO_DEPTH = sha_pkg::FifoDepthDefault
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sha_in_if.sink    i_in,
    sha_out_if.source o_res
);
    import sha_pkg::*;

    logic     full, empty, pop;
    t_in_beat head;

    // front end: accept beats into the queue
    assign i_in.ready = !full;

    sha_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in.valid),
        .i_data  (i_in.payload),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (head)
    );

    // back end: block fill, padding, rounds, digest
    sha_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_data  (head),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import sha_pkg::*;

    localparam int unsigned WatchdogLimit = 40000;
    localparam int unsigned DrainCycles   = 200;

    logic i_clk;
    logic i_rst_n;

    sha_in_if  in_ch ();
    sha_out_if res_ch ();

    sha256_byte_stream_hasher i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_res   (res_ch.source)
    );

    // model state of the hasher
    logic [31:0] chain_h [8];
    logic [7:0]  blk_bytes [64];
    int unsigned blk_fill;
    logic [63:0] bits_done;

    t_in_beat  pending_beats [$];
    t_out_beat digest_queue [$];

    // idle knobs: percent of cycles idle on each side
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned hold_off_cycles;
    int unsigned fail_count;
    int unsigned quiet_cycles;

    localparam logic [31:0] KTab [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [31:0] HInit [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] ror32(logic [31:0] x, int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // one 64-round compression of blk_bytes into chain_h
    task automatic compress_block();
        logic [31:0] sched [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, s0, s1;
        for (int i = 0; i < 16; i++)
            sched[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
        for (int i = 16; i < 64; i++) begin
            s0 = ror32(sched[i-15], 7) ^ ror32(sched[i-15], 18) ^ (sched[i-15] >> 3);
            s1 = ror32(sched[i-2], 17) ^ ror32(sched[i-2], 19) ^ (sched[i-2] >> 10);
            sched[i] = s1 + sched[i-7] + s0 + sched[i-16];
        end
        v = chain_h;
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTab[i] + sched[i];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain_h[i] = chain_h[i] + v[i];
    endtask

    function automatic void hash_restart();
        chain_h   = HInit;
        blk_fill  = 0;
        bits_done = '0;
    endfunction

    // absorb one accepted beat, queue the digest on message end
    task automatic absorb_beat(t_in_beat b);
        logic [63:0] msg_bits;
        int unsigned n;
        t_out_beat   o;
        if (b.byte_valid) begin
            blk_bytes[blk_fill] = b.data_byte;
            blk_fill++;
            if (blk_fill == 64) begin
                compress_block();
                bits_done = bits_done + 64'd512;
                blk_fill  = 0;
            end
        end
        if (b.end_of_message) begin
            n = blk_fill;
            msg_bits = bits_done + 64'(n) * 64'd8;
            blk_bytes[n] = 8'h80;
            n++;
            if (n > 56) begin
                while (n < 64) begin
                    blk_bytes[n] = 8'h00;
                    n++;
                end
                compress_block();
                n = 0;
            end
            while (n < 56) begin
                blk_bytes[n] = 8'h00;
                n++;
            end
            for (int i = 0; i < 8; i++)
                blk_bytes[56+i] = msg_bits[63-8*i -: 8];
            compress_block();
            for (int i = 0; i < 8; i++) begin
                o.digest_word = chain_h[i];
                o.word_index  = 3'(i);
                o.last_word   = (i == 7);
                digest_queue = {digest_queue, o};
            end
            hash_restart();
        end
    endtask

    function automatic t_in_beat mk_beat(logic [7:0] d, logic bv, logic eom);
        t_in_beat b;
        b.data_byte      = d;
        b.byte_valid     = bv;
        b.end_of_message = eom;
        return b;
    endfunction

    task automatic queue_beat(t_in_beat b);
        pending_beats = {pending_beats, b};
    endtask

    // message of len random bytes, closed either by the last byte or an empty end
    task automatic add_message(int unsigned len);
        bit joined;
        joined = (len > 0) && $urandom_range(0, 1);
        for (int unsigned i = 0; i < len; i++) begin
            // occasional idle beat mid-message: no byte, no end
            if ($urandom_range(0, 15) == 0)
                queue_beat(mk_beat(8'($urandom), 1'b0, 1'b0));
            queue_beat(mk_beat(8'($urandom), 1'b1, joined && (i == len - 1)));
        end
        if (!joined)
            queue_beat(mk_beat(8'($urandom), 1'b0, 1'b1));
    endtask

    task automatic wait_drained();
        while (pending_beats.size() != 0 || digest_queue.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // sender side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid   <= 1'b0;
            in_ch.payload <= '0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                absorb_beat(in_ch.payload);
                void'(pending_beats.pop_front());
            end
            if (pending_beats.size() > 0 && !(in_ch.valid && !in_ch.ready)) begin
                // present the next beat unless idling this cycle
                if ($urandom_range(0, 99) >= send_idle_pct) begin
                    in_ch.valid <= 1'b1;
                    in_ch.payload <= pending_beats[0];
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end else if (!(in_ch.valid && !in_ch.ready)) begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // receiver side with hold-off counter
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (hold_off_cycles > 0) begin
                hold_off_cycles <= hold_off_cycles - 1;
                res_ch.ready    <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // result check
    always @(posedge i_clk) begin
        t_out_beat exp_w;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (digest_queue.size() == 0) begin
                $display("%0t: unexpected digest beat, expected none, got %h", $time,
                    res_ch.payload);
                fail_count++;
            end else begin
                exp_w = digest_queue.pop_front();
                if (res_ch.payload.digest_word !== exp_w.digest_word) begin
                    $display("%0t: digest_word expected %h got %h", $time,
                        exp_w.digest_word, res_ch.payload.digest_word);
                    fail_count++;
                end
                if (res_ch.payload.word_index !== exp_w.word_index) begin
                    $display("%0t: word_index expected %0d got %0d", $time,
                        exp_w.word_index, res_ch.payload.word_index);
                    fail_count++;
                end
                if (res_ch.payload.last_word !== exp_w.last_word) begin
                    $display("%0t: last_word expected %b got %b", $time,
                        exp_w.last_word, res_ch.payload.last_word);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no accepted beat on either side
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int unsigned len;
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.payload   = '0;
        res_ch.ready    = 1'b0;
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        hold_off_cycles = 0;
        fail_count      = 0;
        quiet_cycles    = 0;
        hash_restart();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty message, extremes of byte values, 55/56/63/64-byte boundaries
        queue_beat(mk_beat(8'hff, 1'b0, 1'b1));
        queue_beat(mk_beat(8'h00, 1'b1, 1'b1));
        queue_beat(mk_beat(8'hff, 1'b1, 1'b0));
        queue_beat(mk_beat(8'h55, 1'b0, 1'b0));
        queue_beat(mk_beat(8'haa, 1'b1, 1'b1));
        queue_beat(mk_beat(8'h61, 1'b1, 1'b0));
        queue_beat(mk_beat(8'h62, 1'b1, 1'b0));
        queue_beat(mk_beat(8'h63, 1'b1, 1'b0));
        queue_beat(mk_beat(8'h00, 1'b0, 1'b1));
        wait_drained();
        // long receiver hold-off while the next messages keep coming
        hold_off_cycles = 600;
        add_message(55);
        add_message(56);
        add_message(63);
        add_message(64);
        wait_drained();

        // random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 74 : 35) : 0;
            recv_idle_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 74 : 35) : 0;
            for (int m = 0; m < 2; m++) begin
                case ($urandom_range(0, 3))
                    0: len = $urandom_range(0, 8);
                    1: len = $urandom_range(50, 70);
                    default: len = $urandom_range(0, 24);
                endcase
                add_message(len);
            end
            wait_drained();
        end
        repeat (DrainCycles) @(posedge i_clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/sha_pkg.sv
rtl/sha_if.sv
rtl/sha_fifo.sv
rtl/sha_core.sv
rtl/sha256_byte_stream_hasher.sv
tb/tb_top.sv
